// File: design/nlf_pkg.sv
// shared constants and register codes for the nonlinear ladder filter
package nlf_pkg;

    localparam int SAMPLE_BITS_DEFAULT     = 24;
    localparam int FRACTION_BITS_DEFAULT   = 19;
    localparam int MAX_SOLVE_STEPS_DEFAULT = 4;
    localparam int TANH_ADDR_BITS_DEFAULT  = 10;

    localparam int GAIN_W     = 15;
    localparam int FEEDBACK_W = 18;
    localparam int DRIVE_W    = 23;
    localparam int OPB_W      = 31;   // serial multiplier B operand width
    localparam int DERIV_W    = 34;   // loop derivative and jacobian
    localparam int Q30_SHIFT  = 30;
    localparam int COEF_SHIFT = 16;
    localparam int UPD_SHIFT  = 15;
    localparam int FB_PRESHIFT = 14;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_GAIN      = 2'd0,
        REG_FEEDBACK  = 2'd1,
        REG_DRIVE     = 2'd2,
        REG_DRIVE_INV = 2'd3
    } reg_idx_t;

endpackage

// File: design/nlf_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
module nlf_mul import nlf_pkg::*; #(
    parameter int A_W = DERIV_W,
    parameter int B_W = OPB_W
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [A_W-1:0]       a_in,
    input  logic [B_W-1:0]       b_in,
    output logic                 done,
    output logic [A_W+B_W-1:0]   prod
);

    localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

    logic [A_W-1:0]   a_reg;
    logic [A_W-1:0]   hi_reg;
    logic [B_W-1:0]   lo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [A_W:0]     sum;

    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : {(A_W+1){1'b0}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(B_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= a_in;
            hi_reg <= '0;
            lo_reg <= b_in;
        end else if (busy_reg) begin
            hi_reg <= sum[A_W:1];
            lo_reg <= {sum[0], lo_reg[B_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

// File: design/nlf_div.sv
// restoring divider, one quotient bit per cycle
module nlf_div import nlf_pkg::*; #(
    parameter int N_W = 63,
    parameter int D_W = DERIV_W
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic           done,
    output logic [N_W-1:0] quo
);

    localparam int CNT_W = $clog2(N_W);

    logic [N_W-1:0]   quo_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[N_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(N_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
            quo_reg <= {quo_reg[N_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: design/nonlinear_ladder_filter_newton.sv
// four-pole tanh ladder filter, feedback loop solved by newton steps
// One word in, one filtered word out. Every product runs through a single bit-serial
// multiplier, and the newton quotient and the table build run through a bit-serial divider
// (one quotient bit per cycle). Each word takes at most MAX_SOLVE_STEPS newton steps,
// fewer when the residual or the jacobian is zero, then a final ladder pass and the
// state update. After reset the tanh table (2^TANH_TABLE_ADDR_BITS + 1 entries) is
// computed in place, and no word is taken meanwhile; register writes are taken at any
// time. Gain and drive registers are set over the register port.
module nonlinear_ladder_filter_newton import nlf_pkg::*; #(
    parameter int SAMPLE_BITS          = SAMPLE_BITS_DEFAULT,
    parameter int FRACTION_BITS        = FRACTION_BITS_DEFAULT,
    parameter int MAX_SOLVE_STEPS      = MAX_SOLVE_STEPS_DEFAULT,
    parameter int TANH_TABLE_ADDR_BITS = TANH_ADDR_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready
);

    localparam int SB   = SAMPLE_BITS;
    localparam int FB   = FRACTION_BITS;
    localparam int AB   = TANH_TABLE_ADDR_BITS;
    localparam int TS   = FB + 2 - AB;
    localparam int TLEN = (1 << AB) + 1;
    localparam int MAW  = AB + 1;
    localparam int GW   = (SB > FB + 5) ? SB : FB + 5;
    localparam int MA1  = ((GW > SB) ? GW : SB) + 1;
    localparam int MA   = (MA1 > DERIV_W) ? MA1 : DERIV_W;
    localparam int PW   = MA + OPB_W;
    localparam int WW   = PW + 1;
    localparam int CW   = WW + 2;
    localparam int NW   = (GW + 31 > 63) ? GW + 31 : 63;
    localparam int GNW  = NW + 2;
    localparam int TW   = (SB + 22 - FB > FB + 3) ? SB + 22 - FB : FB + 3;
    localparam int SCW  = $clog2(MAX_SOLVE_STEPS + 1);
    localparam int ZW   = 25;

    localparam logic signed [CW-1:0] SMAX_C = {{(CW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [CW-1:0] SMIN_C = ~SMAX_C;
    localparam logic signed [GNW-1:0] GLIM_C = GNW'(10) <<< FB;
    localparam logic [OPB_W-1:0] ONE31 = OPB_W'(1) << Q30_SHIFT;
    localparam logic [DERIV_W-1:0] ONEJ = DERIV_W'(1) << Q30_SHIFT;

    typedef enum logic [1:0] {M_SOLVE, M_FIN, M_UPD} mode_t;

    typedef enum logic [5:0] {
        S_TZ2, S_TZ3, S_TZ5, S_TQ1, S_TQ2, S_TA, S_TSQ, S_TDIV, S_TNEXT, S_TWR,
        S_IDLE, S_LSTART, S_LIN, S_SHMAG, S_SHT, S_RD0, S_RD1, S_RD2, S_SHINT,
        S_SHV, S_SHSL, S_SHEND, S_STY, S_D1, S_D2, S_D3, S_CHECK, S_NEWT,
        S_UPD, S_UPDS, S_UPDW, S_DONE, S_WAIT
    } state_t;

    function automatic logic signed [SB-1:0] sat_s(input logic signed [CW-1:0] v);
        if (v > SMAX_C) return SMAX_C[SB-1:0];
        else if (v < SMIN_C) return SMIN_C[SB-1:0];
        else return v[SB-1:0];
    endfunction

    // product shifted down, truncated toward zero, sign applied
    function automatic logic signed [WW-1:0] tz(input logic [PW-1:0] p, input logic neg,
                                                 input int sh);
        logic [PW-1:0] m;
        m = p >> sh;
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    // configuration registers
    logic [GAIN_W-1:0]     gain_reg;
    logic [FEEDBACK_W-1:0] fb_reg;
    logic [DRIVE_W-1:0]    drive_reg;
    logic [DRIVE_W-1:0]    dinv_reg;

    state_t state_reg;
    state_t ret_reg;
    mode_t  mode_reg;

    logic                   mul_go_reg;
    logic                   mul_neg_reg;
    logic [MA-1:0]          mul_a_reg;
    logic [OPB_W-1:0]       mul_b_reg;
    logic                   mul_done;
    logic [PW-1:0]          mul_p;
    logic                   div_go_reg;
    logic                   div_neg_reg;
    logic [NW-1:0]          div_n_reg;
    logic [DERIV_W-1:0]     div_d_reg;
    logic                   div_done;
    logic [NW-1:0]          div_q;

    logic [MAW-1:0]         ti_reg;
    logic [2:0]             iter_reg;
    logic [31:0]            z2_reg, z3_reg, z5_reg, a_reg;
    logic [ZW-1:0]          z;

    logic signed [SB-1:0]   x_reg;
    logic signed [GW-1:0]   guess_reg;
    logic signed [SB-1:0]   s_reg [4];
    logic signed [SB-1:0]   y_reg [4];
    logic signed [SB-1:0]   cur_reg;
    logic signed [SB-1:0]   v_reg;
    logic signed [DERIV_W-1:0] d_reg;
    logic [1:0]             sidx_reg;
    logic [SCW-1:0]         step_reg;
    logic                   shneg_reg;
    logic [TW-1:0]          t_reg;
    logic [OPB_W-1:0]       th_reg, tlo_reg, slope_reg;
    logic                   m_valid_reg;
    logic signed [SB-1:0]   m_data_reg;

    logic [OPB_W-1:0]       tanh_mem [TLEN];
    logic [OPB_W-1:0]       rd_data_reg;
    logic [MAW-1:0]         rd_addr;
    logic                   t_sat;
    logic [AB-1:0]          t_idx;

    logic signed [SB:0]     diff_w;
    logic signed [GW:0]     res_w;
    logic [GW:0]            res_mag;
    logic signed [DERIV_W:0] jac_w;
    logic signed [GNW-1:0]  qs_w, gn_w;
    logic signed [SB-1:0]   s_cur;

    assign z      = ZW'(ti_reg) << (24 - AB);
    assign t_sat  = |t_reg[TW-1:FB+2];
    assign t_idx  = t_reg[FB+1:TS];
    assign s_cur  = s_reg[sidx_reg];
    assign diff_w = (SB+1)'(v_reg) - (SB+1)'(s_cur);
    assign res_w  = (GW+1)'(guess_reg) - (GW+1)'(y_reg[3]);
    assign res_mag = res_w[GW] ? $unsigned(-res_w) : $unsigned(res_w);
    assign jac_w  = $signed({1'b0, ONEJ}) - (DERIV_W+1)'(d_reg);
    assign qs_w   = div_neg_reg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
    assign gn_w   = GNW'(guess_reg) - qs_w;

    always_comb begin
        case (state_reg)
            S_RD1:   rd_addr = {1'b0, t_idx} + 1'b1;
            default: rd_addr = t_sat ? MAW'(TLEN - 1) : {1'b0, t_idx};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_TWR) tanh_mem[ti_reg] <= a_reg[OPB_W-1:0];
        rd_data_reg <= tanh_mem[rd_addr];
    end

    nlf_mul #(.A_W(MA), .B_W(OPB_W)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_go_reg),
        .a_in(mul_a_reg), .b_in(mul_b_reg), .done(mul_done), .prod(mul_p)
    );

    nlf_div #(.N_W(NW), .D_W(DERIV_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_go_reg),
        .num(div_n_reg), .den(div_d_reg), .done(div_done), .quo(div_q)
    );

    // register port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg  <= '0;
            fb_reg    <= '0;
            drive_reg <= DRIVE_W'(1) << FB;
            dinv_reg  <= DRIVE_W'(1) << FB;
        end else if (psel && penable && pwrite) begin
            case (reg_idx_t'(paddr[3:2]))
                REG_GAIN:      gain_reg  <= pwdata[GAIN_W-1:0];
                REG_FEEDBACK:  fb_reg    <= pwdata[FEEDBACK_W-1:0];
                REG_DRIVE:     drive_reg <= pwdata[DRIVE_W-1:0];
                REG_DRIVE_INV: dinv_reg  <= pwdata[DRIVE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx_t'(paddr[3:2]))
            REG_GAIN:      prdata = APB_DATA_W'(gain_reg);
            REG_FEEDBACK:  prdata = APB_DATA_W'(fb_reg);
            REG_DRIVE:     prdata = APB_DATA_W'(drive_reg);
            REG_DRIVE_INV: prdata = APB_DATA_W'(dinv_reg);
            default:       prdata = '0;
        endcase
    end

    assign pready       = 1'b1;
    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_TZ2;
            ret_reg     <= S_IDLE;
            mode_reg    <= M_SOLVE;
            ti_reg      <= '0;
            iter_reg    <= '0;
            sidx_reg    <= '0;
            step_reg    <= '0;
            mul_go_reg  <= 1'b0;
            div_go_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++) s_reg[i] <= '0;
        end else begin
            mul_go_reg <= 1'b0;
            div_go_reg <= 1'b0;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                // table build: series at t/256, then eight doublings
                S_TZ2: begin
                    mul_a_reg <= MA'(z); mul_b_reg <= OPB_W'(z); mul_neg_reg <= 1'b0;
                    mul_go_reg <= 1'b1; ret_reg <= S_TZ3; state_reg <= S_WAIT;
                end
                S_TZ3: begin
                    z2_reg <= 32'(mul_p >> Q30_SHIFT);
                    mul_a_reg <= MA'(mul_p >> Q30_SHIFT); mul_b_reg <= OPB_W'(z);
                    mul_go_reg <= 1'b1; ret_reg <= S_TZ5; state_reg <= S_WAIT;
                end
                S_TZ5: begin
                    z3_reg <= 32'(mul_p >> Q30_SHIFT);
                    mul_a_reg <= MA'(mul_p >> Q30_SHIFT); mul_b_reg <= OPB_W'(z2_reg);
                    mul_go_reg <= 1'b1; ret_reg <= S_TQ1; state_reg <= S_WAIT;
                end
                S_TQ1: begin
                    z5_reg <= 32'(mul_p >> Q30_SHIFT);
                    div_n_reg <= NW'(z3_reg); div_d_reg <= DERIV_W'(3);
                    div_go_reg <= 1'b1; ret_reg <= S_TQ2; state_reg <= S_WAIT;
                end
                S_TQ2: begin
                    a_reg <= 32'(z) - 32'(div_q);
                    div_n_reg <= NW'(z5_reg) << 1; div_d_reg <= DERIV_W'(15);
                    div_go_reg <= 1'b1; ret_reg <= S_TA; state_reg <= S_WAIT;
                end
                S_TA: begin
                    a_reg <= a_reg + 32'(div_q);
                    iter_reg <= '0;
                    state_reg <= S_TSQ;
                end
                S_TSQ: begin
                    mul_a_reg <= MA'(a_reg); mul_b_reg <= OPB_W'(a_reg);
                    mul_go_reg <= 1'b1; ret_reg <= S_TDIV; state_reg <= S_WAIT;
                end
                S_TDIV: begin
                    div_n_reg <= NW'(a_reg) << (Q30_SHIFT + 1);
                    div_d_reg <= ONEJ + DERIV_W'(mul_p >> Q30_SHIFT);
                    div_go_reg <= 1'b1; ret_reg <= S_TNEXT; state_reg <= S_WAIT;
                end
                S_TNEXT: begin
                    a_reg <= 32'(div_q);
                    iter_reg <= iter_reg + 1'b1;
                    state_reg <= (iter_reg == 3'd7) ? S_TWR : S_TSQ;
                end
                S_TWR: begin
                    if (ti_reg == MAW'(TLEN - 1)) begin
                        state_reg <= S_IDLE;
                    end else begin
                        ti_reg <= ti_reg + 1'b1;
                        state_reg <= S_TZ2;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        x_reg     <= s_sample_in;
                        guess_reg <= GW'(s_reg[3]);
                        step_reg  <= '0;
                        mode_reg  <= M_SOLVE;
                        state_reg <= S_LSTART;
                    end
                end
                // ladder pass for the current guess
                S_LSTART: begin
                    mul_a_reg <= guess_reg[GW-1] ? MA'($unsigned(-guess_reg))
                                                 : MA'($unsigned(guess_reg));
                    mul_neg_reg <= guess_reg[GW-1];
                    mul_b_reg <= OPB_W'(fb_reg);
                    mul_go_reg <= 1'b1; ret_reg <= S_LIN; state_reg <= S_WAIT;
                end
                S_LIN: begin
                    cur_reg  <= sat_s(CW'(x_reg) - CW'(tz(mul_p, mul_neg_reg, COEF_SHIFT)));
                    d_reg    <= -$signed({2'b00, fb_reg, {FB_PRESHIFT{1'b0}}});
                    sidx_reg <= '0;
                    state_reg <= S_SHMAG;
                end
                // saturator
                S_SHMAG: begin
                    shneg_reg <= cur_reg[SB-1];
                    mul_a_reg <= cur_reg[SB-1] ? MA'($unsigned(-cur_reg))
                                               : MA'($unsigned(cur_reg));
                    mul_neg_reg <= 1'b0;
                    mul_b_reg <= OPB_W'(dinv_reg);
                    mul_go_reg <= 1'b1; ret_reg <= S_SHT; state_reg <= S_WAIT;
                end
                S_SHT: begin
                    t_reg <= TW'(mul_p >> FB);
                    state_reg <= S_RD0;
                end
                S_RD0: state_reg <= S_RD1;
                S_RD1: begin
                    tlo_reg <= rd_data_reg;
                    th_reg  <= rd_data_reg;
                    state_reg <= t_sat ? S_SHV : S_RD2;
                end
                S_RD2: begin
                    mul_a_reg <= MA'(rd_data_reg - tlo_reg);
                    mul_b_reg <= OPB_W'(t_reg[TS-1:0]);
                    mul_neg_reg <= 1'b0;
                    mul_go_reg <= 1'b1; ret_reg <= S_SHINT; state_reg <= S_WAIT;
                end
                S_SHINT: begin
                    th_reg <= tlo_reg + OPB_W'(mul_p >> TS);
                    state_reg <= S_SHV;
                end
                S_SHV: begin
                    mul_a_reg <= MA'(th_reg); mul_b_reg <= OPB_W'(drive_reg);
                    mul_neg_reg <= shneg_reg;
                    mul_go_reg <= 1'b1; ret_reg <= S_SHSL; state_reg <= S_WAIT;
                end
                S_SHSL: begin
                    v_reg <= sat_s(CW'(tz(mul_p, mul_neg_reg, Q30_SHIFT)));
                    mul_a_reg <= MA'(th_reg); mul_b_reg <= th_reg;
                    mul_neg_reg <= 1'b0;
                    mul_go_reg <= 1'b1; ret_reg <= S_SHEND; state_reg <= S_WAIT;
                end
                S_SHEND: begin
                    slope_reg <= ONE31 - OPB_W'(mul_p >> Q30_SHIFT);
                    state_reg <= (mode_reg == M_UPD) ? S_UPDS : S_STY;
                end
                // stage output and loop derivative
                S_STY: begin
                    mul_a_reg <= diff_w[SB] ? MA'($unsigned(-diff_w)) : MA'($unsigned(diff_w));
                    mul_neg_reg <= diff_w[SB];
                    mul_b_reg <= OPB_W'(gain_reg);
                    mul_go_reg <= 1'b1; ret_reg <= S_D1; state_reg <= S_WAIT;
                end
                S_D1: begin
                    y_reg[sidx_reg] <= sat_s(CW'(s_cur) +
                                             CW'(tz(mul_p, mul_neg_reg, COEF_SHIFT)));
                    mul_a_reg <= d_reg[DERIV_W-1] ? MA'($unsigned(-d_reg))
                                                  : MA'($unsigned(d_reg));
                    mul_neg_reg <= d_reg[DERIV_W-1];
                    mul_b_reg <= slope_reg;
                    mul_go_reg <= 1'b1; ret_reg <= S_D2; state_reg <= S_WAIT;
                end
                S_D2: begin
                    mul_a_reg <= MA'(mul_p >> Q30_SHIFT);
                    mul_b_reg <= OPB_W'(gain_reg);
                    mul_go_reg <= 1'b1; ret_reg <= S_D3; state_reg <= S_WAIT;
                end
                S_D3: begin
                    d_reg   <= DERIV_W'(tz(mul_p, mul_neg_reg, COEF_SHIFT));
                    cur_reg <= y_reg[sidx_reg];
                    if (sidx_reg == 2'd3) begin
                        state_reg <= S_CHECK;
                    end else begin
                        sidx_reg  <= sidx_reg + 1'b1;
                        state_reg <= S_SHMAG;
                    end
                end
                S_CHECK: begin
                    if (mode_reg == M_FIN) begin
                        mul_a_reg <= y_reg[3][SB-1] ? MA'($unsigned(-y_reg[3]))
                                                    : MA'($unsigned(y_reg[3]));
                        mul_neg_reg <= y_reg[3][SB-1];
                        mul_b_reg <= OPB_W'(fb_reg);
                        mode_reg <= M_UPD;
                        mul_go_reg <= 1'b1; ret_reg <= S_UPD; state_reg <= S_WAIT;
                    end else if (res_w == '0 || jac_w == '0) begin
                        mode_reg  <= M_FIN;
                        state_reg <= S_LSTART;
                    end else begin
                        div_n_reg <= NW'(res_mag) << Q30_SHIFT;
                        div_d_reg <= jac_w[DERIV_W-1:0];
                        div_neg_reg <= res_w[GW];
                        div_go_reg <= 1'b1; ret_reg <= S_NEWT; state_reg <= S_WAIT;
                    end
                end
                S_NEWT: begin
                    if (gn_w > GLIM_C) guess_reg <= GW'(GLIM_C);
                    else if (gn_w < -GLIM_C) guess_reg <= GW'(-GLIM_C);
                    else guess_reg <= GW'(gn_w);
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == SCW'(MAX_SOLVE_STEPS - 1)) mode_reg <= M_FIN;
                    state_reg <= S_LSTART;
                end
                // state update from the solved output
                S_UPD: begin
                    cur_reg  <= sat_s(CW'(x_reg) - CW'(tz(mul_p, mul_neg_reg, COEF_SHIFT)));
                    sidx_reg <= '0;
                    state_reg <= S_SHMAG;
                end
                S_UPDS: begin
                    mul_a_reg <= diff_w[SB] ? MA'($unsigned(-diff_w)) : MA'($unsigned(diff_w));
                    mul_neg_reg <= diff_w[SB];
                    mul_b_reg <= OPB_W'(gain_reg);
                    mul_go_reg <= 1'b1; ret_reg <= S_UPDW; state_reg <= S_WAIT;
                end
                S_UPDW: begin
                    s_reg[sidx_reg] <= sat_s(CW'(s_cur) +
                                             CW'(tz(mul_p, mul_neg_reg, UPD_SHIFT)));
                    if (sidx_reg == 2'd3) begin
                        state_reg <= S_DONE;
                    end else begin
                        cur_reg   <= y_reg[sidx_reg];
                        sidx_reg  <= sidx_reg + 1'b1;
                        state_reg <= S_SHMAG;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= y_reg[3];
                        state_reg   <= S_IDLE;
                    end
                end
                S_WAIT: begin
                    if (mul_done || div_done) state_reg <= ret_reg;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
